### hdl/svpwm_pkg.sv
// Shared constants, formats and types of the space vector PWM duty generator.
package svpwm_pkg;

   // Input references are signed Q2.14 at the default width.
   localparam int IN_W    = 16;
   localparam int IN_FRAC = IN_W - 2;

   // sqrt(3) in Q16, unsigned.
   localparam int SQRT3_W = 17;
   localparam logic [SQRT3_W-1:0] SQRT3_Q16 = 17'd113512;

   // U1 and U2 are Q30; U2 = -beta shifted up to Q30.
   localparam int U_SHIFT = 30 - IN_FRAC;
   localparam int U_W     = (IN_W + SQRT3_W > 33) ? (IN_W + SQRT3_W) : 33;

   // X, Y and Z are Q31, one bit wider than U1 and U2.
   localparam int XYZ_W = U_W + 1;

   // A sector combination such as Y + 2Z needs two more bits.
   localparam int D_W = XYZ_W + 2;

   // Clamped duty magnitude, 0 .. 2^31.
   localparam int MAG_W = 32;
   localparam logic [MAG_W-1:0] ONE_Q31 = 32'h8000_0000;
   localparam int Q_SHIFT = 31;

   // Configuration register.
   localparam int PERIOD_W = 16;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

   // Output formats.
   localparam int DUTY_W   = 17;
   localparam int PROD_W   = MAG_W + PERIOD_W;
   localparam int SECTOR_W = 3;

   localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;
   localparam logic [SECTOR_W-1:0] SECTOR_6 = 3'd6;

   // Queue between the front and back halves.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } duty_mag_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      duty_mag_type        duty_a;
      duty_mag_type        duty_b;
      duty_mag_type        duty_c;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### hdl/svpwm_front.sv
// Front half: takes references, forms X, Y, Z, picks the sector and clamps the duties.
module svpwm_front import svpwm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [IN_W-1:0] req_v_alpha,
   input  logic signed [IN_W-1:0] req_v_beta,
   input  queue_status_type       queue_status,
   output logic                   push,
   output queue_entry_type        push_entry
);

   // Stage 1: U1 and U2 in Q30.
   logic                  f1_valid_ff;
   logic signed [U_W-1:0] u1_ff, u1_in;
   logic signed [U_W-1:0] u2_ff, u2_in;
   logic signed [U_W-1:0] alpha_ext, beta_ext, sqrt3_ext;

   // Stage 2: X, Y and Z in Q31.
   logic                    f2_valid_ff;
   logic signed [XYZ_W-1:0] x_ff, x_in;
   logic signed [XYZ_W-1:0] y_ff, y_in;
   logic signed [XYZ_W-1:0] z_ff, z_in;

   // Stage 3: sector and clamped duties, ready for the queue.
   logic            f3_valid_ff;
   queue_entry_type entry_ff, entry_in;

   logic signed [D_W-1:0] x_d, y_d, z_d;
   logic signed [D_W-1:0] da, db, dc;
   logic [SECTOR_W-1:0]   sector_sel;
   logic                  x_pos;

   logic f1_adv, f2_adv, f3_adv, accept;

   function automatic duty_mag_type clamp_duty(input logic signed [D_W-1:0] d);
      duty_mag_type    r;
      logic [D_W-1:0]  abs_d;
      abs_d = d[D_W-1] ? D_W'(-d) : D_W'(d);
      r.neg = d[D_W-1];
      if (abs_d > D_W'(ONE_Q31)) begin
         r.mag = ONE_Q31;
      end else begin
         r.mag = abs_d[MAG_W-1:0];
      end
      return r;
   endfunction

   // A stage moves on when it is empty or its successor moves on.
   assign f3_adv    = !f3_valid_ff || !queue_status.full;
   assign f2_adv    = !f2_valid_ff || f3_adv;
   assign f1_adv    = !f1_valid_ff || f2_adv;
   assign req_stall = !f1_adv;
   assign accept    = req_valid && f1_adv;

   assign push       = f3_valid_ff && !queue_status.full;
   assign push_entry = entry_ff;

   always_comb begin
      alpha_ext = {{(U_W-IN_W){req_v_alpha[IN_W-1]}}, req_v_alpha};
      beta_ext  = {{(U_W-IN_W){req_v_beta[IN_W-1]}}, req_v_beta};
      sqrt3_ext = U_W'(SQRT3_Q16);
      u1_in     = alpha_ext * sqrt3_ext;
      u2_in     = (-beta_ext) <<< U_SHIFT;
   end

   always_comb begin
      x_in = {u2_ff, 1'b0};
      y_in = {u1_ff[U_W-1], u1_ff} + {u2_ff[U_W-1], u2_ff};
      z_in = {u2_ff[U_W-1], u2_ff} - {u1_ff[U_W-1], u1_ff};
   end

   always_comb begin
      x_d   = {{(D_W-XYZ_W){x_ff[XYZ_W-1]}}, x_ff};
      y_d   = {{(D_W-XYZ_W){y_ff[XYZ_W-1]}}, y_ff};
      z_d   = {{(D_W-XYZ_W){z_ff[XYZ_W-1]}}, z_ff};
      x_pos = !x_ff[XYZ_W-1] && (x_ff != '0);

      // A value of exactly zero is neither negative nor positive.
      if (y_ff[XYZ_W-1]) begin
         if (z_ff[XYZ_W-1]) begin
            sector_sel = SECTOR_5;
         end else begin
            sector_sel = x_pos ? SECTOR_3 : SECTOR_4;
         end
      end else begin
         if (z_ff[XYZ_W-1]) begin
            sector_sel = x_pos ? SECTOR_1 : SECTOR_6;
         end else begin
            sector_sel = SECTOR_2;
         end
      end

      case (sector_sel)
         SECTOR_1: begin
            da = y_d;
            db = -y_d;
            dc = y_d + (z_d <<< 1);
         end
         SECTOR_2: begin
            da = x_d - (z_d <<< 1);
            db = -x_d;
            dc = x_d;
         end
         SECTOR_3: begin
            da = -z_d;
            db = z_d - (x_d <<< 1);
            dc = z_d;
         end
         SECTOR_4: begin
            da = y_d;
            db = -y_d;
            dc = (x_d <<< 1) - y_d;
         end
         SECTOR_5: begin
            da = (y_d <<< 1) - x_d;
            db = -x_d;
            dc = x_d;
         end
         default: begin
            da = -z_d;
            db = -z_d - (y_d <<< 1);
            dc = z_d;
         end
      endcase

      entry_in.sector = sector_sel;
      entry_in.duty_a = clamp_duty(da);
      entry_in.duty_b = clamp_duty(db);
      entry_in.duty_c = clamp_duty(dc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else begin
         if (f1_adv) begin
            f1_valid_ff <= accept;
         end
         if (f2_adv) begin
            f2_valid_ff <= f1_valid_ff;
         end
         if (f3_adv) begin
            f3_valid_ff <= f2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         u1_ff <= u1_in;
         u2_ff <= u2_in;
      end
      if (f2_adv && f1_valid_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
      if (f3_adv && f2_valid_ff) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### hdl/svpwm_queue.sv
// Short first-in first-out queue between the front and back halves.
module svpwm_queue import svpwm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  pop_entry,
   output queue_status_type status
);

   queue_entry_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_entry    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !status.full) |=> !status.empty)
      else $error("queue lost a written item");
`endif

endmodule

### hdl/svpwm_back.sv
// Back half: scales the clamped duties by the PWM period and holds the result.
module svpwm_back import svpwm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [PERIOD_W-1:0]       pwm_period,
   input  queue_status_type          queue_status,
   input  queue_entry_type           pop_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DUTY_W-1:0]  rsp_duty_a,
   output logic signed [DUTY_W-1:0]  rsp_duty_b,
   output logic signed [DUTY_W-1:0]  rsp_duty_c,
   output logic [SECTOR_W-1:0]       rsp_sector
);

   // Stage 1: magnitudes times period, truncated.
   logic                b1_valid_ff;
   logic [DUTY_W-1:0]   qa_ff, qa_in, qb_ff, qb_in, qc_ff, qc_in;
   logic                na_ff, nb_ff, nc_ff;
   logic [SECTOR_W-1:0] sec_ff;

   // Stage 2: signed output register.
   logic                     out_valid_ff;
   logic signed [DUTY_W-1:0] duty_a_ff, duty_b_ff, duty_c_ff;
   logic [SECTOR_W-1:0]      sector_ff;

   logic b1_adv, out_adv;

   function automatic logic [DUTY_W-1:0] scale_mag(input logic [MAG_W-1:0] mag,
                                                   input logic [PERIOD_W-1:0] period);
      logic [PROD_W-1:0] prod;
      prod = {{PERIOD_W{1'b0}}, mag} * {{MAG_W{1'b0}}, period};
      return DUTY_W'(prod >> Q_SHIFT);
   endfunction

   assign out_adv = !out_valid_ff || !rsp_stall;
   assign b1_adv  = !b1_valid_ff || out_adv;
   assign pop     = !queue_status.empty && b1_adv;

   assign rsp_valid  = out_valid_ff;
   assign rsp_duty_a = duty_a_ff;
   assign rsp_duty_b = duty_b_ff;
   assign rsp_duty_c = duty_c_ff;
   assign rsp_sector = sector_ff;

   always_comb begin
      qa_in = scale_mag(pop_entry.duty_a.mag, pwm_period);
      qb_in = scale_mag(pop_entry.duty_b.mag, pwm_period);
      qc_in = scale_mag(pop_entry.duty_c.mag, pwm_period);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (b1_adv) begin
            b1_valid_ff <= pop;
         end
         if (out_adv) begin
            out_valid_ff <= b1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         qa_ff  <= qa_in;
         qb_ff  <= qb_in;
         qc_ff  <= qc_in;
         na_ff  <= pop_entry.duty_a.neg;
         nb_ff  <= pop_entry.duty_b.neg;
         nc_ff  <= pop_entry.duty_c.neg;
         sec_ff <= pop_entry.sector;
      end
      if (out_adv && b1_valid_ff) begin
         duty_a_ff <= na_ff ? $signed(DUTY_W'(-qa_ff)) : $signed(qa_ff);
         duty_b_ff <= nb_ff ? $signed(DUTY_W'(-qb_ff)) : $signed(qb_ff);
         duty_c_ff <= nc_ff ? $signed(DUTY_W'(-qc_ff)) : $signed(qc_ff);
         sector_ff <= sec_ff;
      end
   end

endmodule

### hdl/space_vector_pwm_duty.sv
// Top level of the three-phase space vector PWM duty generator.
//
// Usage: each item on the req channel is one stationary-frame voltage
// reference, req_v_alpha and req_v_beta in signed Q2.14. For every item the
// rsp channel returns one item with three signed compare values
// (rsp_duty_a/b/c, the clamped normalized duty times the PWM period,
// truncated toward zero) and the sector number 1 to 6.
// Both channels use valid and stall; an item moves at a clock edge where
// valid is high and stall is low. The csr channel writes the PWM period; it
// is always ready and should only be written while no item is in flight.
// The accepting edge loads the first of three front stages (multiply, X/Y/Z
// sums, sector select and clamp); the queue slot and the two back stages
// (period multiply, sign and output register) follow the front stages, and
// the output register drives rsp_valid.
// Throughput is one item per cycle, set by the pipeline stages; every stage
// moves each cycle while the receiver takes items.
// When the receiver stalls, the back half holds its result steady and the
// front half keeps filling the four-entry queue; req_stall rises only once
// the queue and the front stages are full.
// Synchronous reset empties all stages and the queue and sets the period
// to 1000; no stored items survive it.
module space_vector_pwm_duty import svpwm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [IN_W-1:0]    req_v_alpha,
   input  logic signed [IN_W-1:0]    req_v_beta,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DUTY_W-1:0]  rsp_duty_a,
   output logic signed [DUTY_W-1:0]  rsp_duty_b,
   output logic signed [DUTY_W-1:0]  rsp_duty_c,
   output logic [SECTOR_W-1:0]       rsp_sector,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [PERIOD_W-1:0]       csr_wdata
);

   // The period register is written whenever the csr channel presents data.
   logic [PERIOD_W-1:0] pwm_period_ff;

   // Connections through the queue that separates the two halves.
   logic             push, pop;
   queue_entry_type  push_entry, pop_entry;
   queue_status_type queue_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff <= PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         pwm_period_ff <= csr_wdata;
      end
   end

   svpwm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_v_alpha  (req_v_alpha),
      .req_v_beta   (req_v_beta),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   svpwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (queue_status)
   );

   svpwm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pwm_period   (pwm_period_ff),
      .queue_status (queue_status),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_duty_a   (rsp_duty_a),
      .rsp_duty_b   (rsp_duty_b),
      .rsp_duty_c   (rsp_duty_c),
      .rsp_sector   (rsp_sector)
   );

endmodule

### sim/space_vector_pwm_duty_check.sv
`timescale 1ns / 100ps
// Scoreboard for space_vector_pwm_duty: predicts each result item and checks it in order.
module space_vector_pwm_duty_check import svpwm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [IN_W-1:0]   req_v_alpha,
   input  logic signed [IN_W-1:0]   req_v_beta,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DUTY_W-1:0] rsp_duty_a,
   input  logic signed [DUTY_W-1:0] rsp_duty_b,
   input  logic signed [DUTY_W-1:0] rsp_duty_c,
   input  logic [SECTOR_W-1:0]      rsp_sector,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [PERIOD_W-1:0]      csr_wdata,
   output int                       duty_mismatches,
   output int                       duties_owed
);

   typedef struct packed {
      logic signed [DUTY_W-1:0] duty_a;
      logic signed [DUTY_W-1:0] duty_b;
      logic signed [DUTY_W-1:0] duty_c;
      logic [SECTOR_W-1:0]      sector;
   } phase_duty_type;

   localparam longint FULL_SCALE = longint'(1) << Q_SHIFT;

   logic [PERIOD_W-1:0] period_shadow = PERIOD_RESET;
   phase_duty_type      owed_q[$];

   // Clamp a Q31 duty to [-1, 1], scale by the period, truncate toward zero.
   function automatic logic signed [DUTY_W-1:0] scale_to_period(
      input longint d, input logic [PERIOD_W-1:0] period);
      longint m;
      if (d > FULL_SCALE) d = FULL_SCALE;
      if (d < -FULL_SCALE) d = -FULL_SCALE;
      m = (d < 0) ? -d : d;
      m = (m * longint'(period)) >> Q_SHIFT;
      if (d < 0) m = -m;
      return m[DUTY_W-1:0];
   endfunction

   function automatic phase_duty_type compute_phase_duty(
      input logic signed [IN_W-1:0] alpha, input logic signed [IN_W-1:0] beta,
      input logic [PERIOD_W-1:0] period);
      longint u1, u2, x, y, z, da, db, dc;
      phase_duty_type r;
      u1 = longint'(alpha) * longint'(SQRT3_Q16);
      u2 = -longint'(beta) * (longint'(1) << U_SHIFT);
      x  = 2 * u2;
      y  = u1 + u2;
      z  = u2 - u1;
      // Exact zero is neither negative nor positive on every sign test.
      if (y < 0) begin
         if (z < 0) r.sector = SECTOR_5;
         else r.sector = (x > 0) ? SECTOR_3 : SECTOR_4;
      end else begin
         if (z < 0) r.sector = (x > 0) ? SECTOR_1 : SECTOR_6;
         else r.sector = SECTOR_2;
      end
      case (r.sector)
         SECTOR_1: begin
            da = y;         db = -y;         dc = y + 2 * z;
         end
         SECTOR_2: begin
            da = x - 2 * z; db = -x;         dc = x;
         end
         SECTOR_3: begin
            da = -z;        db = z - 2 * x;  dc = z;
         end
         SECTOR_4: begin
            da = y;         db = -y;         dc = 2 * x - y;
         end
         SECTOR_5: begin
            da = 2 * y - x; db = -x;         dc = x;
         end
         default: begin
            da = -z;        db = -z - 2 * y; dc = z;
         end
      endcase
      r.duty_a = scale_to_period(da, period);
      r.duty_b = scale_to_period(db, period);
      r.duty_c = scale_to_period(dc, period);
      return r;
   endfunction

   always @(posedge clock) begin : score
      phase_duty_type want;
      phase_duty_type got;
      if (reset) begin
         period_shadow <= PERIOD_RESET;
         owed_q.delete();
         duties_owed <= 0;
      end else begin
         if (csr_valid && csr_ready) period_shadow <= csr_wdata;
         if (req_valid && !req_stall)
            owed_q.push_back(compute_phase_duty(req_v_alpha, req_v_beta, period_shadow));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_duty_a, rsp_duty_b, rsp_duty_c, rsp_sector};
            if (owed_q.size() == 0) begin
               if (duty_mismatches < 10)
                  $display("%0t: unexpected item a=%0d b=%0d c=%0d sector=%0d", $realtime,
                           got.duty_a, got.duty_b, got.duty_c, got.sector);
               duty_mismatches <= duty_mismatches + 1;
            end else begin
               want = owed_q.pop_front();
               if (want != got) begin
                  if (duty_mismatches < 10)
                     $display({"%0t: duty mismatch, expected a=%0d b=%0d c=%0d sector=%0d,",
                               " got a=%0d b=%0d c=%0d sector=%0d"}, $realtime,
                              want.duty_a, want.duty_b, want.duty_c, want.sector,
                              got.duty_a, got.duty_b, got.duty_c, got.sector);
                  duty_mismatches <= duty_mismatches + 1;
               end
            end
         end
         duties_owed <= owed_q.size();
      end
   end

endmodule

### sim/space_vector_pwm_duty_test.sv
`timescale 1ns / 100ps
// Top of the space_vector_pwm_duty testbench: clock, reset, stimulus and verdict.
module space_vector_pwm_duty_test;
   import svpwm_pkg::*;

   // Cycles with no handshake on any channel before the run is declared hung.
   // The longest correct quiet stretch is the receiver hold-off plus a
   // pipeline drain, well under this.
   localparam int QUIET_LIMIT = 1000;
   // Random items per segment; each segment runs under one PWM period.
   localparam int SEG_ITEMS = 102;
   localparam int SEG_COUNT = 15;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int HOLD_CYCLES = 80;
   // Directed references: extremes, sector centers and exact sector borders.
   localparam int DIR_N = 23;

   // 8192 and 14189 sit at exactly 60 degrees on the Q2.14 grid, so they make
   // Y or Z exactly zero and exercise the sign tests at their borders.
   int dir_alpha [DIR_N] = '{
      0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768,
      16384, 8192, -8192, -16384, -8192, 8192,
      16384, -16384, 1, 0, -1, 0, 4000, -4000};
   int dir_beta  [DIR_N] = '{
      0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767,
      0, 14189, 14189, 0, -14189, -14189,
      28378, 28378, 0, 1, 0, -1, 2000, -2000};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   logic signed [IN_W-1:0]   req_v_alpha = '0;
   logic signed [IN_W-1:0]   req_v_beta  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   logic signed [DUTY_W-1:0] rsp_duty_a;
   logic signed [DUTY_W-1:0] rsp_duty_b;
   logic signed [DUTY_W-1:0] rsp_duty_c;
   logic [SECTOR_W-1:0]      rsp_sector;
   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [PERIOD_W-1:0]      csr_wdata   = '0;

   int duty_mismatches;
   int duties_owed;

   // Idle rates in percent. The sender rate is only read by the stimulus
   // process; the receiver rate crosses processes, so it is set with <=.
   int send_idle_pct  = 33;
   int recv_stall_pct = 49;
   int phase_no       = 1;
   logic hold_active  = 1'b0;
   int quiet_cycles   = 0;

   space_vector_pwm_duty dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_v_alpha (req_v_alpha),
      .req_v_beta  (req_v_beta),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_duty_a  (rsp_duty_a),
      .rsp_duty_b  (rsp_duty_b),
      .rsp_duty_c  (rsp_duty_c),
      .rsp_sector  (rsp_sector),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   space_vector_pwm_duty_check check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_v_alpha     (req_v_alpha),
      .req_v_beta      (req_v_beta),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_duty_a      (rsp_duty_a),
      .rsp_duty_b      (rsp_duty_b),
      .rsp_duty_c      (rsp_duty_c),
      .rsp_sector      (rsp_sector),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .duty_mismatches (duty_mismatches),
      .duties_owed     (duties_owed)
   );

   always #1 clock = ~clock;

   // Reset is held high at the start and never raised again.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // The receiver stalls at random, or solidly while a hold-off is active.
   always @(posedge clock) begin
      if (hold_active) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Once the sender stops idling, the receiver holds off long enough for the
   // queue and the front stages to fill, so req_stall has to rise while the
   // sender keeps offering items.
   initial begin
      wait (phase_no == 3);
      repeat (30) @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // The watchdog restarts on any handshake and ends a hung run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one reference and returns at the edge that accepts it. Valid
   // stays high afterwards, so back-to-back items never drop it; it only
   // falls for a random idle gap, before a period write or at the end of the run.
   task automatic send_reference(input logic signed [IN_W-1:0] alpha,
                                 input logic signed [IN_W-1:0] beta);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_v_alpha <= alpha;
      req_v_beta  <= beta;
      do @(posedge clock); while (req_stall);
   endtask

   // The period may only change with nothing in flight. Every item yields a
   // result, so an empty scoreboard means the pipe is empty; a few more
   // cycles are allowed anyway before the write.
   task automatic write_period(input logic [PERIOD_W-1:0] period);
      req_valid <= 1'b0;
      do @(posedge clock); while (duties_owed != 0);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= period;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int seg;
      int n;
      int k;
      logic signed [IN_W-1:0] alpha;
      logic signed [IN_W-1:0] beta;
      logic [PERIOD_W-1:0]    period;

      do @(posedge clock); while (reset);

      // Directed items run under the reset period of 1000.
      for (n = 0; n < DIR_N; n++)
         send_reference(IN_W'(dir_alpha[n]), IN_W'(dir_beta[n]));

      // Random segments. The first five idle the sender a third of the time
      // and the receiver about half; the next five swap the rates; the last
      // five run flat out. The period steps through its extremes, a zero that
      // must force every duty to zero, the reset value and random values.
      for (seg = 0; seg < SEG_COUNT; seg++) begin
         case (seg)
            0:       period = 16'hFFFF;
            1:       period = 16'd1;
            5:       period = 16'd0;
            10:      period = PERIOD_RESET;
            default: period = PERIOD_W'($urandom_range(1, 65535));
         endcase
         write_period(period);
         if (seg == 5) begin
            send_idle_pct = 49;
            recv_stall_pct <= 33;
            phase_no <= 2;
         end else if (seg == 10) begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
            phase_no <= 3;
         end
         for (n = 0; n < SEG_ITEMS; n++) begin
            k = $urandom_range(9);
            if (k < 5) begin
               // Anywhere in the Q2.14 square, mostly overmodulated.
               alpha = IN_W'($urandom);
               beta  = IN_W'($urandom);
            end else if (k < 8) begin
               // Within plus or minus one on each axis, where the clamp acts less often.
               alpha = IN_W'($urandom_range(0, 32768) - 16384);
               beta  = IN_W'($urandom_range(0, 32768) - 16384);
            end else if (k == 8) begin
               // Exactly on a sector border at one or two times unit length.
               k     = $urandom_range(1, 2) * ($urandom_range(1) ? 1 : -1);
               alpha = IN_W'(8192 * k);
               beta  = IN_W'(($urandom_range(1) ? 14189 : -14189) * k);
            end else begin
               // One axis exactly zero.
               alpha = IN_W'($urandom);
               beta  = '0;
               if ($urandom_range(1)) begin
                  beta  = alpha;
                  alpha = '0;
               end
            end
            send_reference(alpha, beta);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (duties_owed != 0);
      // A late extra item would show up within the pipeline latency.
      repeat (20) @(posedge clock);
      if (duty_mismatches == 0 && duties_owed == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
